FILE: rtl/mfp_pkg.sv
package mfp_pkg;

    localparam int NUM_CHANNELS = 16;
    localparam int CH_WIDTH     = 4;
    localparam int SEL_WIDTH    = 5;

    // Upper nibble of a MIDI status byte
    localparam logic [3:0] TYPE_NOTE_OFF = 4'h8;
    localparam logic [3:0] TYPE_NOTE_ON  = 4'h9;
    localparam logic [3:0] TYPE_CONTROL  = 4'hB;

    // Controller numbers and values
    localparam logic [6:0] CTRL_PORTA   = 7'd65;
    localparam logic [6:0] CTRL_ALL_OFF = 7'd123;
    localparam logic [6:0] PORTA_ON_VAL = 7'd127;
    localparam logic [6:0] PORTA_THRESH = 7'd64;

    // channel_select values
    localparam logic [SEL_WIDTH-1:0] SEL_ALL = 5'd0;
    localparam logic [SEL_WIDTH-1:0] SEL_MAX = 5'd16;

endpackage

FILE: rtl/midi_fingered_portamento_core.sv
// Channel   Direction  Handshake            Transaction
// s_*       in         s_valid / s_ready    one 3-byte MIDI message + frame offset
// m_*       out        m_valid / m_ready    one emitted message, m_last on the final one
// cfg_*     in         cfg_valid / cfg_ready  channel_select write (always ready)
//
// Two-stage flow: accept (count RAM read issued) -> execute (count updated, results
// loaded into the output register). Results reach m_* from the output register, which
// execute loads only when the output register is free.
// One input per cycle while m_ready is high and each yields one result; an input that
// also emits portamento keeps the output register for both, one per ready cycle.
// Reset: counts read as zero through per-channel valid bits, enable set,
// channel_select cleared. No clearing pass.
// A stalled m_ready backs up into the execute stage, then into s_ready.
module midi_fingered_portamento_core
    import mfp_pkg::*;
#(
    parameter int COUNT_WIDTH = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [7:0]           s_status_byte,
    input  logic [7:0]           s_data_one,
    input  logic [7:0]           s_data_two,
    input  logic [15:0]          s_frame_offset,

    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [7:0]           m_out_status,
    output logic [7:0]           m_out_data_one,
    output logic [7:0]           m_out_data_two,
    output logic [15:0]          m_out_offset,
    output logic                 m_last,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [SEL_WIDTH-1:0] cfg_channel_select
);

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    // ---------------- configuration ----------------
    logic [SEL_WIDTH-1:0] chan_sel_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chan_sel_reg <= SEL_ALL;
        end else if (cfg_valid && cfg_ready) begin
            chan_sel_reg <= cfg_channel_select;
        end
    end

    // ---------------- execute stage registers ----------------
    logic        ex_valid_reg;
    logic [7:0]  ex_status_reg;
    logic [7:0]  ex_data_one_reg;
    logic [7:0]  ex_data_two_reg;
    logic [15:0] ex_offset_reg;

    logic        s_fire;
    logic        ex_fire;
    logic        out_free;

    assign s_fire  = s_valid && s_ready;
    assign ex_fire = ex_valid_reg && out_free;
    assign s_ready = !ex_valid_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ex_valid_reg <= 1'b0;
        end else if (s_fire) begin
            ex_valid_reg <= 1'b1;
        end else if (ex_fire) begin
            ex_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            ex_status_reg   <= s_status_byte;
            ex_data_one_reg <= s_data_one;
            ex_data_two_reg <= s_data_two;
            ex_offset_reg   <= s_frame_offset;
        end
    end

    // ---------------- count memory ----------------
    logic [CH_WIDTH-1:0]    ex_ch;
    logic [CH_WIDTH-1:0]    ram_rd_addr;
    logic [COUNT_WIDTH-1:0] ram_rd_data;
    logic                   ram_wr_en;
    logic [COUNT_WIDTH-1:0] cnt_new;
    logic                   cnt_wr;

    assign ex_ch = ex_status_reg[3:0];
    // Re-read the held item's entry while it waits so the data stays current
    assign ram_rd_addr = s_fire ? s_status_byte[3:0] : ex_ch;
    assign ram_wr_en   = ex_fire && cnt_wr;

    mfp_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (NUM_CHANNELS)
    ) u_count_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ex_ch),
        .wr_data (cnt_new),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Per-channel written flags: unwritten entries read as zero after reset
    logic [NUM_CHANNELS-1:0] cnt_vld_reg;
    // Last cycle's write, which the RAM read in the same cycle missed
    logic                    fwd_valid_reg;
    logic [CH_WIDTH-1:0]     fwd_addr_reg;
    logic [COUNT_WIDTH-1:0]  fwd_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_vld_reg   <= '0;
            fwd_valid_reg <= 1'b0;
        end else begin
            fwd_valid_reg <= ram_wr_en;
            if (ram_wr_en) begin
                cnt_vld_reg[ex_ch] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ram_wr_en) begin
            fwd_addr_reg <= ex_ch;
            fwd_data_reg <= cnt_new;
        end
    end

    // ---------------- execute logic ----------------
    logic                   power_on_reg;
    logic                   power_next;
    logic [COUNT_WIDTH-1:0] cnt_cur;
    logic [3:0]             ex_type;
    logic [6:0]             ex_d1;
    logic [6:0]             ex_d2;
    logic [SEL_WIDTH-1:0]   sel_clamped;
    logic                   ex_active;
    logic                   is_off;
    logic                   is_on;
    logic                   ex_gen;
    logic                   ex_gen_on;
    logic                   ex_swallow;

    assign ex_type     = ex_status_reg[7:4];
    assign ex_d1       = ex_data_one_reg[6:0];
    assign ex_d2       = ex_data_two_reg[6:0];
    assign sel_clamped = (chan_sel_reg > SEL_MAX) ? SEL_MAX : chan_sel_reg;
    assign ex_active   = power_on_reg &&
                         ((sel_clamped == SEL_ALL) ||
                          (ex_ch == CH_WIDTH'(sel_clamped - 5'd1)));
    // Note-on with zero velocity behaves as note-off
    assign is_off = (ex_type == TYPE_NOTE_OFF) ||
                    ((ex_type == TYPE_NOTE_ON) && (ex_d2 == 7'd0));
    assign is_on  = (ex_type == TYPE_NOTE_ON) && (ex_d2 != 7'd0);

    always_comb begin
        if (fwd_valid_reg && (fwd_addr_reg == ex_ch)) begin
            cnt_cur = fwd_data_reg;
        end else if (cnt_vld_reg[ex_ch]) begin
            cnt_cur = ram_rd_data;
        end else begin
            cnt_cur = '0;
        end

        cnt_new    = cnt_cur;
        cnt_wr     = 1'b0;
        ex_gen     = 1'b0;
        ex_gen_on  = 1'b0;
        ex_swallow = 1'b0;
        power_next = power_on_reg;

        if (is_off) begin
            // Decrement clamped at zero; portamento-off if active and it lands on zero
            cnt_wr = 1'b1;
            if (cnt_cur != '0) begin
                cnt_new = cnt_cur - COUNT_WIDTH'(1);
            end
            ex_gen = ex_active && (cnt_new == '0);
        end else if (is_on) begin
            // Saturated count: no change, nothing generated
            if (cnt_cur != COUNT_MAX) begin
                cnt_wr    = 1'b1;
                cnt_new   = cnt_cur + COUNT_WIDTH'(1);
                ex_gen    = ex_active && (cnt_cur == '0);
                ex_gen_on = 1'b1;
            end
        end else if (ex_type == TYPE_CONTROL) begin
            if (ex_d1 == CTRL_ALL_OFF) begin
                cnt_wr  = 1'b1;
                cnt_new = '0;
                ex_gen  = ex_active;
            end else if ((ex_d1 == CTRL_PORTA) && ex_active) begin
                ex_swallow = 1'b1;
                power_next = (ex_d2 >= PORTA_THRESH);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            power_on_reg <= 1'b1;
        end else if (ex_fire) begin
            power_on_reg <= power_next;
        end
    end

    // ---------------- output register ----------------
    // Holds up to two results: optional generated CC65, then the pass-through.
    logic        out_gen_reg;
    logic        out_pass_reg;
    logic        out_gen_on_reg;
    logic [7:0]  out_status_reg;
    logic [7:0]  out_data_one_reg;
    logic [7:0]  out_data_two_reg;
    logic [15:0] out_offset_reg;
    logic        m_fire;

    assign m_valid  = out_gen_reg || out_pass_reg;
    assign m_last   = out_gen_reg ? !out_pass_reg : 1'b1;
    assign m_fire   = m_valid && m_ready;
    assign out_free = !m_valid || (m_fire && m_last);

    assign m_out_status   = out_gen_reg ? {TYPE_CONTROL, out_status_reg[3:0]} : out_status_reg;
    assign m_out_data_one = out_gen_reg ? {1'b0, CTRL_PORTA} : out_data_one_reg;
    assign m_out_data_two = out_gen_reg ? {1'b0, (out_gen_on_reg ? PORTA_ON_VAL : 7'd0)}
                                        : out_data_two_reg;
    assign m_out_offset   = out_offset_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_gen_reg  <= 1'b0;
            out_pass_reg <= 1'b0;
        end else if (ex_fire) begin
            out_gen_reg  <= ex_gen;
            out_pass_reg <= !ex_swallow;
        end else if (m_fire) begin
            if (out_gen_reg) begin
                out_gen_reg <= 1'b0;
            end else begin
                out_pass_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ex_fire) begin
            out_gen_on_reg   <= ex_gen_on;
            out_status_reg   <= ex_status_reg;
            out_data_one_reg <= ex_data_one_reg;
            out_data_two_reg <= ex_data_two_reg;
            out_offset_reg   <= ex_offset_reg;
        end
    end

    // ---------------- assertions ----------------
    // A generated message is always followed by its pass-through
    a_gen_has_pass: assert property (@(posedge aclk) disable iff (!aresetn)
        out_gen_reg |-> out_pass_reg)
        else $error("generated message without pass-through");

    // Generation only on an active channel
    a_gen_active: assert property (@(posedge aclk) disable iff (!aresetn)
        (ex_fire && ex_gen) |-> ex_active)
        else $error("portamento generated on inactive channel");

    // Enable flag moves only when an item leaves execute
    a_power_change: assert property (@(posedge aclk) disable iff (!aresetn)
        !$stable(power_on_reg) |-> $past(ex_fire))
        else $error("enable changed without an executed item");

    // A swallowed item leaves no result behind
    a_swallow_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (ex_fire && ex_swallow) |=> !m_valid)
        else $error("swallowed item produced a result");

    // Forwarded entry is always marked written
    a_fwd_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        fwd_valid_reg |-> cnt_vld_reg[fwd_addr_reg])
        else $error("forwarded entry not marked written");

endmodule

FILE: rtl/mfp_ram.sv
module mfp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Read returns old data on a same-address write
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: test/tb_midi_fingered_portamento_core.sv
`timescale 1ns / 1ps

module tb_midi_fingered_portamento_core;
    import mfp_pkg::*;

    localparam int COUNT_WIDTH    = 8;
    localparam int PHASE_ITEMS    = 240;   // random transactions per channel_select setting
    localparam int SETTLE_CYCLES  = 8;     // pipeline is two stages deep
    localparam int WATCHDOG_LIMIT = 2000;  // cycles without any handshake

    // One MIDI message on the result channel
    typedef struct {
        logic [7:0]  status;
        logic [7:0]  data_one;
        logic [7:0]  data_two;
        logic [15:0] offset;
        logic        last_flag;
    } midi_msg_t;

    // Predicts the portamento messages and pass-through for each input
    // transaction and checks results in order.
    class portamento_scoreboard;
        logic [COUNT_WIDTH-1:0] chan_count [NUM_CHANNELS];
        logic                   glide_enabled;
        logic [SEL_WIDTH-1:0]   chan_select;
        midi_msg_t              expected_q [$];
        int                     errors;

        function new();
            foreach (chan_count[i]) chan_count[i] = '0;
            glide_enabled = 1'b1;
            chan_select   = SEL_ALL;
            errors        = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_input(input logic [7:0] status, input logic [7:0] data_one,
                                 input logic [7:0] data_two, input logic [15:0] offset);
            logic [3:0]             kind;
            logic [3:0]             chan;
            logic [6:0]             num;
            logic [6:0]             val;
            logic [SEL_WIDTH-1:0]   sel;
            logic [SEL_WIDTH-1:0]   target;
            logic                   active;
            logic                   has_glide;
            logic                   swallow;
            logic [COUNT_WIDTH-1:0] cnt;
            midi_msg_t              glide;
            midi_msg_t              pass;

            kind   = status[7:4];
            chan   = status[3:0];
            num    = data_one[6:0];
            val    = data_two[6:0];
            sel    = (chan_select > SEL_MAX) ? SEL_MAX : chan_select;
            target = (sel == SEL_ALL) ? {1'b0, chan} : sel - 5'd1;
            active = glide_enabled && (target == {1'b0, chan});
            cnt    = chan_count[chan];

            has_glide       = 1'b0;
            swallow         = 1'b0;
            glide.status    = {TYPE_CONTROL, chan};
            glide.data_one  = {1'b0, CTRL_PORTA};
            glide.data_two  = 8'h00;
            glide.offset    = offset;
            glide.last_flag = 1'b0;

            // note-on with zero velocity behaves as note-off
            if (kind == TYPE_NOTE_OFF || (kind == TYPE_NOTE_ON && val == 7'd0)) begin
                if (cnt != '0) cnt = cnt - COUNT_WIDTH'(1);
                has_glide = (cnt == '0) && active;
            end else if (kind == TYPE_NOTE_ON) begin
                if (cnt != {COUNT_WIDTH{1'b1}}) begin
                    cnt = cnt + COUNT_WIDTH'(1);
                    if (cnt == COUNT_WIDTH'(1) && active) begin
                        has_glide      = 1'b1;
                        glide.data_two = {1'b0, PORTA_ON_VAL};
                    end
                end
            end else if (kind == TYPE_CONTROL) begin
                if (num == CTRL_ALL_OFF) begin
                    has_glide = active;
                    cnt       = '0;
                end else if (num == CTRL_PORTA && active) begin
                    swallow       = 1'b1;
                    glide_enabled = (val >= PORTA_THRESH);
                end
            end
            chan_count[chan] = cnt;

            if (has_glide) expected_q.insert(expected_q.size(), glide);
            if (!swallow) begin
                pass.status    = status;
                pass.data_one  = data_one;
                pass.data_two  = data_two;
                pass.offset    = offset;
                pass.last_flag = 1'b1;
                expected_q.insert(expected_q.size(), pass);
            end
        endfunction

        function void compare_field(input string field, input logic [15:0] want,
                                    input logic [15:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
            end
        endfunction

        function void check_result(input midi_msg_t got);
            midi_msg_t want;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none actual %h %h %h", $time,
                         got.status, got.data_one, got.data_two);
            end else begin
                want = expected_q.pop_front();
                compare_field("status",   16'(want.status),   16'(got.status));
                compare_field("data_one", 16'(want.data_one), 16'(got.data_one));
                compare_field("data_two", 16'(want.data_two), 16'(got.data_two));
                compare_field("offset",   want.offset,        got.offset);
                compare_field("last",     16'(want.last_flag), 16'(got.last_flag));
            end
        endfunction
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;

    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [7:0]           s_status_byte = '0;
    logic [7:0]           s_data_one = '0;
    logic [7:0]           s_data_two = '0;
    logic [15:0]          s_frame_offset = '0;

    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [7:0]           m_out_status;
    logic [7:0]           m_out_data_one;
    logic [7:0]           m_out_data_two;
    logic [15:0]          m_out_offset;
    logic                 m_last;

    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [SEL_WIDTH-1:0] cfg_channel_select = '0;

    // Stimulus state
    logic                 idle_on = 1'b1;        // random gaps on both channels
    logic [SEL_WIDTH-1:0] cur_select = SEL_ALL;  // what the generator aims at
    int                   quiet_cycles = 0;
    int                   stall_left = 0;
    portamento_scoreboard sb;

    midi_fingered_portamento_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) uut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_status_byte      (s_status_byte),
        .s_data_one         (s_data_one),
        .s_data_two         (s_data_two),
        .s_frame_offset     (s_frame_offset),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_out_status       (m_out_status),
        .m_out_data_one     (m_out_data_one),
        .m_out_data_two     (m_out_data_two),
        .m_out_offset       (m_out_offset),
        .m_last             (m_last),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_channel_select (cfg_channel_select)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // Result sink: stalls at random while idling is on.
    always @(posedge aclk) begin
        if (idle_on && stall_left == 0 && $urandom_range(0, 7) == 0)
            stall_left = $urandom_range(1, 15);
        if (!idle_on)
            stall_left = 0;
        m_ready <= (stall_left == 0);
        if (stall_left != 0)
            stall_left--;
    end

    // Monitors and watchdog in one process so that a result is checked
    // before a transaction accepted on the same edge is predicted.
    always @(posedge aclk) begin
        midi_msg_t got;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                got.status    = m_out_status;
                got.data_one  = m_out_data_one;
                got.data_two  = m_out_data_two;
                got.offset    = m_out_offset;
                got.last_flag = m_last;
                sb.check_result(got);
            end
            if (s_valid && s_ready)
                sb.note_input(s_status_byte, s_data_one, s_data_two, s_frame_offset);
            if (cfg_valid && cfg_ready)
                sb.chan_select = cfg_channel_select;

            if ((m_valid && m_ready) || (s_valid && s_ready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: watchdog expired, %0d results outstanding", $time, sb.pending());
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // One input transaction. Valid stays high into the next call unless
    // an idle burst is inserted first.
    task automatic send_msg(input logic [7:0] status, input logic [7:0] data_one,
                            input logic [7:0] data_two, input logic [15:0] offset);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_status_byte  <= status;
        s_data_one     <= data_one;
        s_data_two     <= data_two;
        s_frame_offset <= offset;
        do @(posedge aclk); while (!(s_valid && s_ready));
    endtask

    // Sender quiet until every predicted result has come out, then SETTLE_CYCLES
    // more for a swallowed message still in flight.
    task automatic wait_for_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic change_select(input logic [SEL_WIDTH-1:0] sel);
        wait_for_results();
        cfg_valid          <= 1'b1;
        cfg_channel_select <= sel;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
        cur_select = sel;
    endtask

    // Mostly note traffic on a "hot" channel the select points at, plus
    // all-notes-off, portamento controller and raw noise. Disabling
    // portamento is permanent, so it is held back unless allowed.
    task automatic send_random(input bit allow_off);
        logic [7:0]  status;
        logic [7:0]  data_one;
        logic [7:0]  data_two;
        logic [3:0]  chan;
        int unsigned pick;

        pick = $urandom_range(0, 99);
        if (cur_select == SEL_ALL)
            chan = 4'($urandom_range(0, 3));
        else if (cur_select >= SEL_MAX)
            chan = 4'd15;
        else
            chan = 4'(cur_select - 5'd1);
        if ($urandom_range(0, 1) == 0)
            chan = 4'($urandom);
        data_one = 8'($urandom);
        data_two = 8'($urandom);

        if (pick < 40) begin
            status = {TYPE_NOTE_ON, chan};
            if (pick < 4) data_two[6:0] = '0;   // zero velocity
        end else if (pick < 75) begin
            status = {TYPE_NOTE_OFF, chan};
        end else if (pick < 85) begin
            status = {TYPE_CONTROL, chan};
            data_one[6:0] = CTRL_ALL_OFF;
        end else if (pick < 92) begin
            status = {TYPE_CONTROL, chan};
            data_one[6:0] = CTRL_PORTA;
        end else begin
            status = 8'($urandom);
        end

        if (status[7:4] == TYPE_CONTROL && data_one[6:0] == CTRL_PORTA && !allow_off)
            data_two[6] = 1'b1;
        send_msg(status, data_one, data_two, 16'($urandom));
    endtask

    task automatic run_phase(input int count, input bit late_off);
        for (int i = 0; i < count; i++)
            send_random(late_off && i >= count - 40);
    endtask

    initial begin
        sb = new();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: all channels active after reset
        send_msg({TYPE_NOTE_ON, 4'd0},  8'd60, 8'd100, 16'h0000);   // first note: porta on
        send_msg({TYPE_NOTE_ON, 4'd0},  8'd64, 8'h7F,  16'h0001);   // second note, no porta
        send_msg({TYPE_NOTE_ON, 4'd0},  8'd62, 8'h80,  16'h0002);   // velocity bits zero -> off
        send_msg({TYPE_NOTE_OFF, 4'd0}, 8'd60, 8'h40,  16'h0003);   // last release: porta off
        send_msg({TYPE_NOTE_OFF, 4'd0}, 8'hFF, 8'hFF,  16'h0004);   // release at zero count
        send_msg({TYPE_NOTE_ON, 4'd15}, 8'h7F, 8'h01,  16'hFFFF);
        send_msg({TYPE_CONTROL, 4'd15}, {1'b0, CTRL_ALL_OFF}, 8'h00, 16'h8000);
        send_msg({TYPE_CONTROL, 4'd3},  {1'b0, CTRL_PORTA}, 8'h7F, 16'h1234); // swallowed
        send_msg({TYPE_CONTROL, 4'd3},  {1'b1, CTRL_PORTA}, 8'hC0, 16'h4321); // threshold
        send_msg({TYPE_CONTROL, 4'd3},  {1'b1, CTRL_ALL_OFF}, 8'hFF, 16'h00FF);
        send_msg({TYPE_CONTROL, 4'd1},  8'd7,  8'h55, 16'hAAAA);    // other controller
        send_msg(8'hA5, 8'h3C, 8'h7F, 16'h5555);                    // aftertouch
        send_msg(8'hE0, 8'h00, 8'h40, 16'h0F0F);                    // pitch bend
        send_msg(8'h00, 8'h00, 8'h00, 16'h0000);
        send_msg(8'hFF, 8'hFF, 8'hFF, 16'hFFFF);
        send_msg(8'hF0, 8'h80, 8'h01, 16'hF0F0);

        run_phase(PHASE_ITEMS, 1'b0);

        // Count saturation on one channel, then release and clear
        for (int i = 0; i < 258; i++)
            send_msg({TYPE_NOTE_ON, 4'd2}, 8'($urandom),
                     {1'($urandom), 7'($urandom_range(1, 127))}, 16'($urandom));
        send_msg({TYPE_NOTE_OFF, 4'd2}, 8'($urandom), 8'($urandom), 16'($urandom));
        send_msg({TYPE_NOTE_OFF, 4'd2}, 8'($urandom), 8'($urandom), 16'($urandom));
        send_msg({TYPE_CONTROL, 4'd2}, {1'b0, CTRL_ALL_OFF}, 8'h00, 16'($urandom));

        // Single-channel settings, the extremes included
        change_select(5'd1);
        run_phase(PHASE_ITEMS, 1'b0);
        change_select(SEL_MAX);
        run_phase(PHASE_ITEMS, 1'b0);
        change_select(5'd31);   // above sixteen acts like sixteen
        run_phase(PHASE_ITEMS, 1'b0);
        change_select(5'($urandom_range(2, 15)));
        run_phase(PHASE_ITEMS, 1'b0);
        change_select(5'($urandom_range(17, 30)));
        run_phase(PHASE_ITEMS, 1'b0);

        // Last part: no idling on either side; portamento may get disabled
        idle_on <= 1'b0;
        change_select(SEL_ALL);
        run_phase(PHASE_ITEMS, 1'b1);
        send_msg({TYPE_CONTROL, 4'd0}, {1'b0, CTRL_PORTA}, 8'h3F, 16'h0100);  // disable
        send_msg({TYPE_NOTE_ON, 4'd0}, 8'd61, 8'h50, 16'h0101);
        send_msg({TYPE_CONTROL, 4'd0}, {1'b0, CTRL_PORTA}, 8'h7F, 16'h0102);  // now passes
        send_msg({TYPE_CONTROL, 4'd0}, {1'b0, CTRL_ALL_OFF}, 8'h00, 16'h0103);

        wait_for_results();
        if (sb.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
